// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, masked while reset is asserted.
`define QPMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle check of post against pre.
`define QPMM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/qpmm_pkg.sv =====
package qpmm_pkg;

	localparam int FRAC_BITS      = 8;
	localparam int INTEGRAL_WIDTH = 40;
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC      = 8;
	localparam int ANGLE_W        = 17;
	localparam int HEIGHT_W       = 24;
	localparam int BATT_W         = 12;
	localparam int MOTOR_W        = 8;
	localparam int NUM_AXES       = 4;

	localparam int ERR_W  = HEIGHT_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int PE_W   = ERR_W + GAIN_W;
	localparam int PI_W   = INTEGRAL_WIDTH + GAIN_W;
	localparam int PD_W   = DIFF_W + GAIN_W;
	localparam int SUM_W  = PI_W + 2;
	localparam int SIG_W  = FRAC_BITS + 10;
	localparam int MIX_W  = SIG_W + 2;

	localparam int SIG_LIM  = 255 << FRAC_BITS;
	localparam int TILT_LIM = 45 << FRAC_BITS;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 40;

	localparam int AXIS_ROLL   = 0;
	localparam int AXIS_PITCH  = 1;
	localparam int AXIS_YAW    = 2;
	localparam int AXIS_HEIGHT = 3;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_BATTERY = 2'd1,
		CAUSE_TILT    = 2'd2,
		CAUSE_OVER    = 2'd3
	} fault_cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP     = 3'd0,
		REG_GAIN_INTEGRAL = 3'd1,
		REG_GAIN_DERIV    = 3'd2,
		REG_TARGET_ROLL   = 3'd3,
		REG_TARGET_PITCH  = 3'd4,
		REG_TARGET_YAW    = 3'd5,
		REG_TARGET_HEIGHT = 3'd6,
		REG_BATTERY_FLOOR = 3'd7
	} reg_index_t;

endpackage

// ===== sv/quad_pid_motor_mixer.sv =====
// Quad X-frame PID motor mixer.
// Input stream (s_*): one sensor frame per transfer carrying roll, pitch, yaw,
// height and the raw battery reading. Output stream (m_*): one transfer per
// frame with four 8-bit motor drives, a fault flag and the fault cause.
// Config port: cfg_we/cfg_index/cfg_data write gains, setpoints and the
// battery floor; write only while no frame is in flight.
// Throughput: one frame per clock while the output is not stalled. Five
// registers lie between input and m_tvalid (input register, error/integral update,
// gain products, PID sum and range check, mix/clamp into the output register).
// The integral and previous-error update closes within the error/integral
// update step, which allows that frame rate.
// Reset: integrals and previous errors clear, registers take their defaults
// (proportional gain 1.0, battery floor 2050), the pipeline empties.
// Stall: while m_tready is low with a result pending, the whole pipeline
// holds and s_tready drops; bubbles inside the pipe move with it and are not
// squeezed out.
`include "assert_macros.svh"

module quad_pid_motor_mixer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// roll_angle, pitch_angle, yaw_angle, height, battery_raw, zero pad
	input  logic [qpmm_pkg::S_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// motor_one, motor_two, motor_three, motor_four, fault, fault_cause, zero pad
	output logic [qpmm_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                             cfg_we,
	input  logic [qpmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qpmm_pkg::CFG_W-1:0]       cfg_data
);
	import qpmm_pkg::*;

	localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
	localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

	// configuration registers
	logic signed [GAIN_W-1:0]   gain_prop_q, gain_integral_q, gain_deriv_q;
	logic signed [ANGLE_W-1:0]  target_roll_q, target_pitch_q, target_yaw_q;
	logic signed [HEIGHT_W-1:0] target_height_q;
	logic [BATT_W-1:0]          battery_floor_q;

	// per-axis state
	logic signed [INTEGRAL_WIDTH-1:0] integ_q [NUM_AXES];
	logic signed [ERR_W-1:0]          last_err_q [NUM_AXES];

	logic adv;

	// stage 1: input register
	logic                       valid_s1;
	logic signed [ANGLE_W-1:0]  roll_s1, pitch_s1, yaw_s1;
	logic signed [HEIGHT_W-1:0] height_s1;
	logic [BATT_W-1:0]          battery_s1;

	// stage 2: errors, derivatives, updated integrals, fault flags
	logic                             valid_s2, batt_low_s2, tilt_s2;
	logic signed [ERR_W-1:0]          err_s2 [NUM_AXES];
	logic signed [DIFF_W-1:0]         diff_s2 [NUM_AXES];
	logic signed [INTEGRAL_WIDTH-1:0] acc_s2 [NUM_AXES];

	// stage 3: gain products
	logic                    valid_s3, batt_low_s3, tilt_s3;
	logic signed [PE_W-1:0]  pe_s3 [NUM_AXES];
	logic signed [PI_W-1:0]  pi_s3 [NUM_AXES];
	logic signed [PD_W-1:0]  pd_s3 [NUM_AXES];

	// stage 4: signals and overrange
	logic                    valid_s4, batt_low_s4, tilt_s4, over_s4;
	logic signed [SIG_W-1:0] sig_s4 [NUM_AXES];

	// stage 5: output register
	logic                    valid_s5, fault_s5;
	fault_cause_t            cause_s5;
	logic [MOTOR_W-1:0]      motor_s5 [NUM_AXES];

	// combinational per-stage results
	logic signed [ERR_W-1:0]          err_c [NUM_AXES];
	logic signed [DIFF_W-1:0]         diff_c [NUM_AXES];
	logic signed [INTEGRAL_WIDTH-1:0] acc_c [NUM_AXES];
	logic signed [ERR_W-1:0]          tgt_c [NUM_AXES];
	logic signed [ERR_W-1:0]          meas_c [NUM_AXES];
	logic                             batt_low_c, tilt_c;
	logic signed [PE_W-1:0]           pe_c [NUM_AXES];
	logic signed [PI_W-1:0]           pi_c [NUM_AXES];
	logic signed [PD_W-1:0]           pd_c [NUM_AXES];
	logic signed [SIG_W-1:0]          sig_c [NUM_AXES];
	logic                             over_c;
	logic [MOTOR_W-1:0]               motor_c [NUM_AXES];
	logic                             fault_c;
	fault_cause_t                     cause_c;

	function automatic logic [MOTOR_W-1:0] drive(input logic signed [MIX_W-1:0] mix);
		logic [MOTOR_W-1:0] res;
		if (mix < 0) begin
			res = '0;
		end else if (mix > SIG_LIM) begin
			res = '1;
		end else begin
			res = mix[FRAC_BITS +: MOTOR_W];
		end
		return res;
	endfunction

	assign adv      = !valid_s5 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = valid_s5;
	assign m_tdata  = {5'b0, cause_s5, fault_s5,
		motor_s5[3], motor_s5[2], motor_s5[1], motor_s5[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= 16'sd256;
			gain_integral_q <= '0;
			gain_deriv_q    <= '0;
			target_roll_q   <= '0;
			target_pitch_q  <= '0;
			target_yaw_q    <= '0;
			target_height_q <= '0;
			battery_floor_q <= 12'd2050;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_GAIN_PROP:     gain_prop_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_INTEGRAL: gain_integral_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DERIV:    gain_deriv_q    <= cfg_data[GAIN_W-1:0];
				REG_TARGET_ROLL:   target_roll_q   <= cfg_data[ANGLE_W-1:0];
				REG_TARGET_PITCH:  target_pitch_q  <= cfg_data[ANGLE_W-1:0];
				REG_TARGET_YAW:    target_yaw_q    <= cfg_data[ANGLE_W-1:0];
				REG_TARGET_HEIGHT: target_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_BATTERY_FLOOR: battery_floor_q <= cfg_data[BATT_W-1:0];
			endcase
		end
	end

	// stage 1 -> 2: error, derivative, saturating integral, battery and tilt flags
	always_comb begin
		logic signed [INTEGRAL_WIDTH:0] isum;
		tgt_c[AXIS_ROLL]    = ERR_W'(target_roll_q);
		tgt_c[AXIS_PITCH]   = ERR_W'(target_pitch_q);
		tgt_c[AXIS_YAW]     = ERR_W'(target_yaw_q);
		tgt_c[AXIS_HEIGHT]  = ERR_W'(target_height_q);
		meas_c[AXIS_ROLL]   = ERR_W'(roll_s1);
		meas_c[AXIS_PITCH]  = ERR_W'(pitch_s1);
		meas_c[AXIS_YAW]    = ERR_W'(yaw_s1);
		meas_c[AXIS_HEIGHT] = ERR_W'(height_s1);
		isum = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			err_c[i]  = tgt_c[i] - meas_c[i];
			diff_c[i] = err_c[i] - last_err_q[i];
			isum      = integ_q[i] + err_c[i];
			if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
				acc_c[i] = isum[INTEGRAL_WIDTH] ? IMIN : IMAX;
			end else begin
				acc_c[i] = isum[INTEGRAL_WIDTH-1:0];
			end
		end
		batt_low_c = battery_s1 < battery_floor_q;
		tilt_c = (roll_s1 > TILT_LIM) || (roll_s1 < -TILT_LIM) ||
			(pitch_s1 > TILT_LIM) || (pitch_s1 < -TILT_LIM);
	end

	// stage 2 -> 3: one product per gain and lane
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			pe_c[i] = err_s2[i] * gain_prop_q;
			pi_c[i] = acc_s2[i] * gain_integral_q;
			pd_c[i] = diff_s2[i] * gain_deriv_q;
		end
	end

	// stage 3 -> 4: exact sum, floor by the gain scale, range check
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] shifted;
		sum = '0;
		shifted = '0;
		over_c = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			sum     = pe_s3[i] + pi_s3[i] + pd_s3[i];
			shifted = sum >>> GAIN_FRAC;
			if ((shifted > SIG_LIM) || (shifted < -SIG_LIM)) begin
				over_c = 1'b1;
			end
			sig_c[i] = shifted[SIG_W-1:0];
		end
	end

	// stage 4 -> 5: X-frame mix, clamp, fault priority
	always_comb begin
		logic signed [MIX_W-1:0] r, p, y, a;
		r = MIX_W'(sig_s4[AXIS_ROLL]);
		p = MIX_W'(sig_s4[AXIS_PITCH]);
		y = MIX_W'(sig_s4[AXIS_YAW]);
		a = MIX_W'(sig_s4[AXIS_HEIGHT]);
		priority if (batt_low_s4) begin
			cause_c = CAUSE_BATTERY;
		end else if (tilt_s4) begin
			cause_c = CAUSE_TILT;
		end else if (over_s4) begin
			cause_c = CAUSE_OVER;
		end else begin
			cause_c = CAUSE_NONE;
		end
		fault_c = cause_c != CAUSE_NONE;
		if (fault_c) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				motor_c[i] = '0;
			end
		end else begin
			motor_c[0] = drive(a + p - r - y);
			motor_c[1] = drive(a + p + r + y);
			motor_c[2] = drive(a - p + r - y);
			motor_c[3] = drive(a - p - r + y);
		end
	end

	// pipeline valids and per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				integ_q[i]    <= '0;
				last_err_q[i] <= '0;
			end
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			if (valid_s1) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					integ_q[i]    <= acc_c[i];
					last_err_q[i] <= err_c[i];
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_s1    <= s_tdata[16:0];
			pitch_s1   <= s_tdata[33:17];
			yaw_s1     <= s_tdata[50:34];
			height_s1  <= s_tdata[74:51];
			battery_s1 <= s_tdata[86:75];

			batt_low_s2 <= batt_low_c;
			tilt_s2     <= tilt_c;
			batt_low_s3 <= batt_low_s2;
			tilt_s3     <= tilt_s2;
			batt_low_s4 <= batt_low_s3;
			tilt_s4     <= tilt_s3;
			over_s4     <= over_c;
			fault_s5    <= fault_c;
			cause_s5    <= cause_c;
			for (int i = 0; i < NUM_AXES; i++) begin
				err_s2[i]   <= err_c[i];
				diff_s2[i]  <= diff_c[i];
				acc_s2[i]   <= acc_c[i];
				pe_s3[i]    <= pe_c[i];
				pi_s3[i]    <= pi_c[i];
				pd_s3[i]    <= pd_c[i];
				sig_s4[i]   <= sig_c[i];
				motor_s5[i] <= motor_c[i];
			end
		end
	end

	`QPMM_ASSERT(a_fault_zero, (valid_s5 && fault_s5) |-> (m_tdata[31:0] == '0), "faulted frame drives a motor")
	`QPMM_ASSERT(a_fault_cause, valid_s5 |-> (fault_s5 == (cause_s5 != CAUSE_NONE)), "fault flag disagrees with cause")
	`QPMM_ASSERT_NEXT(a_integ_hold, !(adv && valid_s1), $stable(integ_q[AXIS_ROLL]), "roll integral moved without a frame")
	`QPMM_ASSERT_NEXT(a_err_hold, !(adv && valid_s1), $stable(last_err_q[AXIS_HEIGHT]), "height error moved without a frame")

endmodule

// ===== bench/quad_pid_motor_mixer_tb.sv =====
module quad_pid_motor_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qpmm_pkg::*;

	localparam int LATENCY    = 5;
	localparam int NUM_REGS   = 8;
	localparam int HOLD_TICKS = 200;
	localparam int HEIGHT_MAX = (1 << (HEIGHT_W - 1)) - 1;
	localparam int HEIGHT_MIN = -(1 << (HEIGHT_W - 1));
	localparam int ANGLE_SPAN = 46080;
	localparam int BATT_FULL  = (1 << BATT_W) - 1;

	typedef struct packed {
		logic [BATT_W-1:0]   battery;
		logic [HEIGHT_W-1:0] height;
		logic [ANGLE_W-1:0]  yaw;
		logic [ANGLE_W-1:0]  pitch;
		logic [ANGLE_W-1:0]  roll;
	} frame_t;

	typedef struct packed {
		fault_cause_t                      cause;
		logic                              fault;
		logic [3:0][MOTOR_W-1:0]           motor;
	} motor_drive_t;

	class motor_mix_model;
		logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
		logic [BATT_W-1:0]        battery_floor;
		longint                   aim [NUM_AXES];
		longint                   integral [NUM_AXES];
		longint                   last_error [NUM_AXES];
		motor_drive_t             expected_drives [$];
		int                       mismatches;
		int                       frames;
		int                       by_cause [4];

		function new();
			gain_p = 16'sd256;
			gain_i = '0;
			gain_d = '0;
			battery_floor = 12'd2050;
		endfunction

		function void set_reg(reg_index_t r, logic [CFG_W-1:0] v);
			case (r)
				REG_GAIN_PROP:     gain_p = v[GAIN_W-1:0];
				REG_GAIN_INTEGRAL: gain_i = v[GAIN_W-1:0];
				REG_GAIN_DERIV:    gain_d = v[GAIN_W-1:0];
				REG_TARGET_ROLL:   aim[AXIS_ROLL] = $signed(v[ANGLE_W-1:0]);
				REG_TARGET_PITCH:  aim[AXIS_PITCH] = $signed(v[ANGLE_W-1:0]);
				REG_TARGET_YAW:    aim[AXIS_YAW] = $signed(v[ANGLE_W-1:0]);
				REG_TARGET_HEIGHT: aim[AXIS_HEIGHT] = $signed(v[HEIGHT_W-1:0]);
				REG_BATTERY_FLOOR: battery_floor = v[BATT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [MOTOR_W-1:0] to_drive(longint mix);
			if (mix < 0) mix = 0;
			if (mix > SIG_LIM) mix = SIG_LIM;
			return MOTOR_W'(mix >>> FRAC_BITS);
		endfunction

		function void accept_frame(logic [S_DATA_W-1:0] data);
			frame_t       f;
			longint       meas [NUM_AXES];
			longint       sig [NUM_AXES];
			longint       e, acc, sum, imax, imin;
			longint       rol, pit, yw, alt;
			bit           over;
			motor_drive_t want;
			f = data[$bits(frame_t)-1:0];
			meas[AXIS_ROLL] = $signed(f.roll);
			meas[AXIS_PITCH] = $signed(f.pitch);
			meas[AXIS_YAW] = $signed(f.yaw);
			meas[AXIS_HEIGHT] = $signed(f.height);
			imax = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
			imin = -imax - 1;
			over = 1'b0;
			for (int x = 0; x < NUM_AXES; x++) begin
				e = aim[x] - meas[x];
				acc = integral[x];
				if (e > 0 && acc > imax - e) acc = imax;
				else if (e < 0 && acc < imin - e) acc = imin;
				else acc += e;
				sum = longint'(gain_p) * e + longint'(gain_i) * acc
					+ longint'(gain_d) * (e - last_error[x]);
				integral[x] = acc;
				last_error[x] = e;
				sig[x] = sum >>> GAIN_FRAC;
				if (sig[x] > SIG_LIM || sig[x] < -SIG_LIM) over = 1'b1;
			end
			if (f.battery < battery_floor) want.cause = CAUSE_BATTERY;
			else if (meas[AXIS_ROLL] > TILT_LIM || meas[AXIS_ROLL] < -TILT_LIM ||
				meas[AXIS_PITCH] > TILT_LIM || meas[AXIS_PITCH] < -TILT_LIM)
				want.cause = CAUSE_TILT;
			else if (over) want.cause = CAUSE_OVER;
			else want.cause = CAUSE_NONE;
			if (want.cause != CAUSE_NONE) begin
				want.motor = '0;
				want.fault = 1'b1;
			end else begin
				rol = sig[AXIS_ROLL];
				pit = sig[AXIS_PITCH];
				yw = sig[AXIS_YAW];
				alt = sig[AXIS_HEIGHT];
				want.motor[0] = to_drive(alt + pit - rol - yw);
				want.motor[1] = to_drive(alt + pit + rol + yw);
				want.motor[2] = to_drive(alt - pit + rol - yw);
				want.motor[3] = to_drive(alt - pit - rol + yw);
				want.fault = 1'b0;
			end
			by_cause[want.cause]++;
			frames++;
			expected_drives.push_back(want);
		endfunction

		function void check_drive(logic [M_DATA_W-1:0] data);
			motor_drive_t got, want;
			got = data[$bits(motor_drive_t)-1:0];
			if (expected_drives.size() == 0) begin
				$display("%0t: result %h arrived with no frame pending", $time, data);
				mismatches++;
				return;
			end
			want = expected_drives.pop_front();
			for (int m = 0; m < 4; m++) begin
				if (got.motor[m] !== want.motor[m]) begin
					$display("%0t: motor %0d expected %0d, got %0d", $time, m + 1,
						want.motor[m], got.motor[m]);
					mismatches++;
				end
			end
			if (got.fault !== want.fault) begin
				$display("%0t: fault expected %b, got %b", $time, want.fault, got.fault);
				mismatches++;
			end
			if (got.cause !== want.cause) begin
				$display("%0t: fault_cause expected %s, got %0d", $time, want.cause.name(),
					got.cause);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	motor_mix_model        sb = new();
	logic [CFG_W-1:0]      setting [NUM_REGS];
	int                    aim_roll, aim_pitch, aim_yaw, aim_height, floor_level;
	int                    tx_idle_pct, rx_idle_pct;
	int                    settings_applied;
	logic                  hold_request;

	quad_pid_motor_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.accept_frame(s_tdata);
			if (m_tvalid && m_tready) sb.check_drive(m_tdata);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_TICKS) @(posedge clk);
				hold_request = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic int rand_span(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic frame_t sensor_frame(int roll, int pitch, int yaw, int height,
		int battery);
		frame_t f;
		f.roll = ANGLE_W'(roll);
		f.pitch = ANGLE_W'(pitch);
		f.yaw = ANGLE_W'(yaw);
		f.height = HEIGHT_W'(height);
		f.battery = BATT_W'(battery);
		return f;
	endfunction

	function automatic frame_t flight_frame();
		frame_t f;
		int     pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			// raw bit patterns
			f.roll = ANGLE_W'($urandom);
			f.pitch = ANGLE_W'($urandom);
			f.yaw = ANGLE_W'($urandom);
			f.height = HEIGHT_W'($urandom);
			f.battery = BATT_W'($urandom);
		end else begin
			f = sensor_frame(aim_roll + rand_span(3000), aim_pitch + rand_span(3000),
				aim_yaw + rand_span(6000),
				aim_height - int'($urandom_range(0, 40000)) + 4000,
				$urandom_range(floor_level, BATT_FULL));
			if (pick < 22) f.roll = ANGLE_W'(rand_span(16000));
			else if (pick < 27) f.pitch = ANGLE_W'(rand_span(16000));
			else if (pick < 32) f.battery = BATT_W'($urandom_range(0, floor_level));
		end
		return f;
	endfunction

	function automatic void store_aims();
		setting[REG_TARGET_ROLL] = CFG_W'(aim_roll);
		setting[REG_TARGET_PITCH] = CFG_W'(aim_pitch);
		setting[REG_TARGET_YAW] = CFG_W'(aim_yaw);
		setting[REG_TARGET_HEIGHT] = CFG_W'(aim_height);
		setting[REG_BATTERY_FLOOR] = CFG_W'(floor_level);
	endfunction

	function automatic void pick_flight_setting();
		aim_roll = rand_span(2000);
		aim_pitch = rand_span(2000);
		aim_yaw = rand_span(20000);
		aim_height = rand_span(1000000);
		floor_level = $urandom_range(0, 3000);
		setting[REG_GAIN_PROP] = CFG_W'(int'($urandom_range(128, 384)));
		setting[REG_GAIN_INTEGRAL] = CFG_W'(rand_span(2));
		setting[REG_GAIN_DERIV] = CFG_W'(rand_span(128));
		store_aims();
	endfunction

	// junk above each register's width must be dropped
	function automatic void pick_extreme_setting(bit upper);
		aim_roll = upper ? ANGLE_SPAN : -ANGLE_SPAN;
		aim_pitch = -aim_roll;
		aim_yaw = aim_roll;
		aim_height = upper ? HEIGHT_MAX : HEIGHT_MIN;
		floor_level = upper ? BATT_FULL : 0;
		setting[REG_GAIN_PROP] = upper ? 24'h5A7FFF : 24'hFF8000;
		setting[REG_GAIN_INTEGRAL] = upper ? 24'hFF8000 : 24'h007FFF;
		setting[REG_GAIN_DERIV] = upper ? 24'h007FFF : 24'hA58000;
		store_aims();
		if (upper) setting[REG_BATTERY_FLOOR] = 24'hC3FFFF;
	endfunction

	task automatic apply_setting();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_data <= setting[i];
			@(posedge clk);
			sb.set_reg(reg_index_t'(i), setting[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic offer_frame(input frame_t f);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_DATA_W'(f);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	function automatic int clip_span(longint v, int span);
		if (v > span) return span;
		if (v < -span) return -span;
		return int'(v);
	endfunction

	// with every setpoint at zero, walk all four integrals back to zero
	task automatic park_integrals();
		while (sb.integral[AXIS_ROLL] != 0 || sb.integral[AXIS_PITCH] != 0 ||
			sb.integral[AXIS_YAW] != 0 || sb.integral[AXIS_HEIGHT] != 0) begin
			offer_frame(sensor_frame(clip_span(sb.integral[AXIS_ROLL], ANGLE_SPAN),
				clip_span(sb.integral[AXIS_PITCH], ANGLE_SPAN),
				clip_span(sb.integral[AXIS_YAW], ANGLE_SPAN),
				clip_span(sb.integral[AXIS_HEIGHT], HEIGHT_MAX), BATT_FULL));
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GAIN_PROP;
		cfg_data = '0;
		hold_request = 1'b0;
		settings_applied = 0;
		tx_idle_pct = 37;
		rx_idle_pct = 61;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on gains: unit proportional, zero setpoints
		offer_frame(sensor_frame(0, 0, 0, 0, BATT_FULL));
		offer_frame(sensor_frame(0, 0, 0, 0, 2050));
		offer_frame(sensor_frame(0, 0, 0, 0, 2049));
		offer_frame(sensor_frame(0, 0, 0, 0, 0));
		offer_frame(sensor_frame(-500, 0, 0, -1000, 3000));
		offer_frame(sensor_frame(0, 300, -700, -20000, 3000));
		offer_frame(sensor_frame(TILT_LIM, 0, 0, -SIG_LIM, 3000));
		offer_frame(sensor_frame(TILT_LIM + 1, 0, 0, -1000, 3000));
		offer_frame(sensor_frame(-TILT_LIM - 1, 0, 0, -1000, 3000));
		offer_frame(sensor_frame(0, TILT_LIM + 1, 0, -1000, 3000));
		offer_frame(sensor_frame(0, -TILT_LIM, 0, -1000, 3000));
		offer_frame(sensor_frame(0, 0, ANGLE_SPAN, 0, 3000));
		offer_frame(sensor_frame(0, 0, -ANGLE_SPAN, -30000, BATT_FULL));
		offer_frame(sensor_frame(0, 0, 0, -SIG_LIM - 1, 3000));
		offer_frame(sensor_frame(0, 0, 0, SIG_LIM + 1, 3000));
		offer_frame(sensor_frame(0, 0, 0, HEIGHT_MIN, BATT_FULL));
		offer_frame(sensor_frame(0, 0, 0, HEIGHT_MAX, BATT_FULL));
		offer_frame(sensor_frame(ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN, HEIGHT_MAX, 0));
		offer_frame(sensor_frame(-65536, 65535, -65536, 0, BATT_FULL));
		offer_frame(sensor_frame(0, 0, 0, 200, BATT_FULL));
		wait_drained();

		pick_flight_setting();
		apply_setting();
		repeat (150) offer_frame(flight_frame());
		wait_drained();

		tx_idle_pct = 61;
		rx_idle_pct = 37;
		pick_flight_setting();
		apply_setting();
		repeat (150) offer_frame(flight_frame());
		wait_drained();
		pick_extreme_setting(1'b1);
		apply_setting();
		repeat (15) offer_frame(flight_frame());
		wait_drained();
		pick_extreme_setting(1'b0);
		apply_setting();
		repeat (15) offer_frame(flight_frame());
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		pick_flight_setting();
		apply_setting();
		repeat (50) offer_frame(flight_frame());
		// hold the output side long enough to back up the input
		hold_request = 1'b1;
		repeat (50) offer_frame(flight_frame());
		wait_drained();
		repeat (50) offer_frame(flight_frame());
		wait_drained();

		// integral-only gain from zeroed integrals: wind the height lane up, then back
		aim_roll = 0;
		aim_pitch = 0;
		aim_yaw = 0;
		aim_height = 0;
		floor_level = 0;
		setting[REG_GAIN_PROP] = '0;
		setting[REG_GAIN_INTEGRAL] = CFG_W'(256);
		setting[REG_GAIN_DERIV] = '0;
		store_aims();
		apply_setting();
		park_integrals();
		repeat (20) offer_frame(sensor_frame(0, 0, 0, -150, BATT_FULL));
		repeat (20) offer_frame(sensor_frame(0, 0, 0, 150, BATT_FULL));
		wait_drained();

		$display("Covered %0d frames under %0d register settings: %0d clean, %0d low battery,",
			sb.frames, settings_applied, sb.by_cause[CAUSE_NONE], sb.by_cause[CAUSE_BATTERY]);
		$display("%0d tilt, %0d overrange; height integral wound up and back with integral gain",
			sb.by_cause[CAUSE_TILT], sb.by_cause[CAUSE_OVER]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/qpmm_pkg.sv
sv/quad_pid_motor_mixer.sv
bench/quad_pid_motor_mixer_tb.sv
